/* design/gjerp_pkg.sv */
// Package for the GPU job event join and row packer.
// Holds shared types, codes and defaults; no dependencies.
package gjerp_pkg;

  localparam int PENDING_ENTRIES_DEF = 16;
  localparam int NUM_TIMELINES_DEF   = 8;
  localparam int MAX_DEPTH_DEF       = 16;
  localparam logic [31:0] SLACK_RESET = 32'd1000000;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_SCHED  = 2'd1;
  localparam logic [1:0] OP_SIGNAL = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  // one bit per event kind: submit, schedule, signal
  localparam logic [2:0] KIND_ALL = 3'b111;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_UPDATE, S_SCAN, S_EMIT
  } state_t;

endpackage

/* design/gpu_job_event_join_and_row_packer.sv */
// Top level of the GPU job event join and row packer; depends on gjerp_pkg.
// Results: a table-full status result is registered from S_MATCH; a job result is registered
// from S_EMIT after S_MATCH, S_UPDATE and S_SCAN, with S_EMIT stepping through the rows.
// Flow: one event at a time, taken only in S_IDLE; an unknown opcode or timeline index is
// dropped at once, and input is held off while a result waits for its transfer.
// Reset: sync active high; clears valid bits, row counts, latest signal times; sets slack.
module gpu_job_event_join_and_row_packer #(
  parameter int PENDING_ENTRIES = gjerp_pkg::PENDING_ENTRIES_DEF,
  parameter int NUM_TIMELINES   = gjerp_pkg::NUM_TIMELINES_DEF,
  parameter int MAX_DEPTH       = gjerp_pkg::MAX_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // fields from bit 0: event time, context_req, seqno, timeline_index,
  // process_id, thread_id, zero fill
  input  logic [183:0] s_tdata,
  input  logic [1:0]   s_tuser,   // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  // fields from bit 0: job_process_id, job_thread_id, job_context, job_seqno,
  // job_timeline, job_row, submit, schedule, hw start, signal times, zero fill
  output logic [375:0] m_tdata,
  output logic [1:0]   m_tuser    // status
);
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int TW = (NUM_TIMELINES > 1) ? $clog2(NUM_TIMELINES) : 1;
  localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int RW = (NUM_TIMELINES * MAX_DEPTH > 1) ?
                      $clog2(NUM_TIMELINES * MAX_DEPTH) : 1;

  // pending store: key words in flops for a parallel match, payload in memory
  logic [2:0]  have   [PENDING_ENTRIES];
  logic [31:0] p_ctx  [PENDING_ENTRIES];
  logic [31:0] p_seq  [PENDING_ENTRIES];
  logic [2:0]  p_tl   [PENDING_ENTRIES];
  logic [45:0] p_id_mem  [PENDING_ENTRIES];
  logic [63:0] p_sub_mem [PENDING_ENTRIES];
  logic [63:0] p_sch_mem [PENDING_ENTRIES];
  logic [63:0] p_sig_mem [PENDING_ENTRIES];
  logic [63:0] latest [NUM_TIMELINES];
  logic [CW-1:0] rows [NUM_TIMELINES];
  logic [63:0] row_mem [NUM_TIMELINES*MAX_DEPTH];

  gjerp_pkg::state_t state, state_next;
  logic [31:0] slack;
  logic [1:0]  op;
  logic [63:0] ts;
  logic [31:0] ctx, seq;
  logic [2:0]  tl;
  logic [45:0] ids;
  logic [PW-1:0] slot;
  logic [2:0]  kinds;
  logic [45:0] r_id;
  logic [63:0] r_sub, r_sch, r_sig, row_rd;
  logic [DW-1:0] d;
  logic [CW-1:0] n;
  logic [TW-1:0] tli;

  assign tli = TW'(tl);
  assign cfg_ready = (state == gjerp_pkg::S_IDLE) && !m_tvalid;
  assign s_tready  = (state == gjerp_pkg::S_IDLE) && !m_tvalid;

  // parallel key match and free search, lowest index wins
  logic hit, free_ok;
  logic [PW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
    for (int e = PENDING_ENTRIES - 1; e >= 0; e--) begin
      if (have[e] != 3'd0 && p_ctx[e] == ctx && p_seq[e] == seq && p_tl[e] == tl) begin
        hit = 1'b1; hit_idx = PW'(e);
      end
      if (have[e] == 3'd0) begin
        free_ok = 1'b1; free_idx = PW'(e);
      end
    end
  end

  logic [2:0] kind;
  assign kind = 3'b001 << op;

  // row scan: row_rd holds row d of the timeline during S_EMIT
  logic [63:0]   sum, hw;
  logic [CW-1:0] d_ext, d_inc, row_sel;
  logic [1:0]    st_sel;
  logic [RW-1:0] row_base;
  logic          fits, more, emit_full, emit_job;

  assign sum      = row_rd + {32'd0, slack};   // wraps at 64 bits
  assign hw       = (r_sch < latest[tli]) ? latest[tli] : r_sch;
  assign d_ext    = CW'(d);
  assign d_inc    = d_ext + 1'b1;
  assign row_base = RW'(tli * MAX_DEPTH);
  assign fits     = (d_ext < n) && (r_sub >= sum);
  assign more     = d_inc < n;
  assign emit_full = (state == gjerp_pkg::S_MATCH) && !hit && !free_ok;
  assign emit_job  = (state == gjerp_pkg::S_EMIT) && (fits || !more);

  // first fit, else append, else reuse the deepest row
  always_comb begin
    priority if (fits) begin
      row_sel = d_ext;
      st_sel  = gjerp_pkg::ST_DONE;
    end else if (n < CW'(MAX_DEPTH)) begin
      row_sel = n;
      st_sel  = gjerp_pkg::ST_DONE;
    end else begin
      row_sel = CW'(MAX_DEPTH - 1);
      st_sel  = gjerp_pkg::ST_SAT;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gjerp_pkg::S_IDLE: begin
        if (s_tvalid && s_tready && s_tuser <= gjerp_pkg::OP_SIGNAL &&
            {29'd0, s_tdata[130:128]} < NUM_TIMELINES)
          state_next = gjerp_pkg::S_MATCH;
      end
      gjerp_pkg::S_MATCH: begin
        state_next = (hit || free_ok) ? gjerp_pkg::S_UPDATE : gjerp_pkg::S_IDLE;
      end
      gjerp_pkg::S_UPDATE: begin
        if ((kinds & kind) == 3'd0 && (kinds | kind) == gjerp_pkg::KIND_ALL)
          state_next = gjerp_pkg::S_SCAN;
        else
          state_next = gjerp_pkg::S_IDLE;
      end
      gjerp_pkg::S_SCAN: begin
        state_next = gjerp_pkg::S_EMIT;
      end
      default: begin
        state_next = (fits || !more) ? gjerp_pkg::S_IDLE : gjerp_pkg::S_EMIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gjerp_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slack <= gjerp_pkg::SLACK_RESET;
      m_tvalid <= 1'b0;
      for (int e = 0; e < PENDING_ENTRIES; e++) have[e] <= 3'd0;
      for (int t = 0; t < NUM_TIMELINES; t++) begin
        latest[t] <= '0; rows[t] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) slack <= cfg_data;
      if (emit_full || emit_job) m_tvalid <= 1'b1;
      else if (m_tready)         m_tvalid <= 1'b0;
      if (state == gjerp_pkg::S_UPDATE && (kinds & kind) == 3'd0)
        have[slot] <= ((kinds | kind) == gjerp_pkg::KIND_ALL) ? 3'd0 : (kinds | kind);
      if (emit_job) begin
        if (!fits && n < CW'(MAX_DEPTH)) rows[tli] <= n + 1'b1;
        if (r_sig > latest[tli]) latest[tli] <= r_sig;
      end
    end
  end

  // datapath and memories, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      gjerp_pkg::S_IDLE: begin
        if (s_tvalid && s_tready) begin
          op <= s_tuser; ts <= s_tdata[63:0]; ctx <= s_tdata[95:64];
          seq <= s_tdata[127:96]; tl <= s_tdata[130:128]; ids <= s_tdata[176:131];
        end
      end
      gjerp_pkg::S_MATCH: begin
        if (hit) begin
          slot <= hit_idx; kinds <= have[hit_idx];
        end else if (free_ok) begin
          slot <= free_idx; kinds <= 3'd0;
          p_ctx[free_idx] <= ctx; p_seq[free_idx] <= seq; p_tl[free_idx] <= tl;
        end else begin
          // table full: key and event time only
          m_tuser <= gjerp_pkg::ST_FULL;
          m_tdata <= {195'd0, ts, 4'd0, tl, seq, ctx, 46'd0};
        end
      end
      gjerp_pkg::S_UPDATE: begin
        if ((kinds & kind) == 3'd0) begin
          unique case (op)
            gjerp_pkg::OP_SUBMIT: begin p_sub_mem[slot] <= ts; p_id_mem[slot] <= ids; end
            gjerp_pkg::OP_SCHED:  p_sch_mem[slot] <= ts;
            default:              p_sig_mem[slot] <= ts;
          endcase
        end
        n <= (rows[tli] > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : rows[tli];
        d <= '0;
      end
      gjerp_pkg::S_SCAN: begin
        // payload reads registered; write of this event landed last cycle
        r_id <= p_id_mem[slot]; r_sub <= p_sub_mem[slot];
        r_sch <= p_sch_mem[slot]; r_sig <= p_sig_mem[slot];
        row_rd <= row_mem[row_base + RW'(d_ext)];
      end
      default: begin
        if (fits || !more) begin
          row_mem[row_base + RW'(row_sel)] <= r_sig;
          m_tuser <= st_sel;
          m_tdata <= {3'd0, r_sig, hw, r_sch, r_sub, 4'(row_sel), tl, seq, ctx, r_id};
        end else begin
          d <= d + 1'b1;
          row_rd <= row_mem[row_base + RW'(d_inc)];
        end
      end
    endcase
  end
endmodule

/* sim/tb.sv */
// Testbench for gpu_job_event_join_and_row_packer: joins submit, schedule and
// fence events and checks job results against an in-bench join/row predictor.
// Depends on gjerp_pkg and the block RTL.
`timescale 1ns / 100ps

module tb;

  localparam int NPEND = gjerp_pkg::PENDING_ENTRIES_DEF;
  localparam int NTL   = gjerp_pkg::NUM_TIMELINES_DEF;
  localparam int DEPTH = gjerp_pkg::MAX_DEPTH_DEF;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [22:0] pid;
    logic [22:0] tid;
    logic [31:0] ctx;
    logic [31:0] seq;
    logic [2:0]  tl;
    logic [3:0]  row;
    logic [63:0] t_sub;
    logic [63:0] t_sch;
    logic [63:0] t_hw;
    logic [63:0] t_sig;
  } job_t;

  // Predictor of the join table and first-fit row packing; holds expected jobs.
  class job_scoreboard;
    logic [31:0] slack;
    logic [2:0]  have [NPEND];
    logic [31:0] p_ctx [NPEND];
    logic [31:0] p_seq [NPEND];
    logic [2:0]  p_tl [NPEND];
    logic [22:0] p_pid [NPEND];
    logic [22:0] p_tid [NPEND];
    logic [63:0] p_sub [NPEND];
    logic [63:0] p_sch [NPEND];
    logic [63:0] p_sig [NPEND];
    logic [63:0] latest [NTL];
    int          rows [NTL];
    logic [63:0] row_end [NTL][DEPTH];
    job_t        pending_jobs[$];
    int          errors;

    function void clear();
      slack = gjerp_pkg::SLACK_RESET;
      foreach (have[i]) have[i] = '0;
      foreach (latest[i]) begin
        latest[i] = '0;
        rows[i] = 0;
      end
      errors = 0;
    endfunction

    // note one accepted event
    function void note_event(logic [1:0] op, logic [63:0] ts, logic [31:0] ctx,
                             logic [31:0] seq, logic [2:0] tl, logic [22:0] pid,
                             logic [22:0] tid);
      int slot;
      logic [2:0] kind;
      job_t j;
      logic [63:0] hw;
      int r;
      bit sat;
      slot = -1;
      if (op > gjerp_pkg::OP_SIGNAL) return;
      kind = 3'b1 << op;
      for (int e = 0; e < NPEND; e++)
        if (slot < 0 && have[e] != 0 && p_ctx[e] == ctx && p_seq[e] == seq && p_tl[e] == tl)
          slot = e;
      if (slot < 0) begin
        for (int e = 0; e < NPEND; e++)
          if (slot < 0 && have[e] == 0) slot = e;
        if (slot < 0) begin
          j = '0;
          j.status = gjerp_pkg::ST_FULL;
          j.ctx = ctx; j.seq = seq; j.tl = tl; j.t_sub = ts;
          pending_jobs = {pending_jobs, j};
          return;
        end
        p_ctx[slot] = ctx; p_seq[slot] = seq; p_tl[slot] = tl;
      end
      if (have[slot] & kind) return;
      have[slot] |= kind;
      unique case (op)
        gjerp_pkg::OP_SUBMIT: begin
          p_sub[slot] = ts; p_pid[slot] = pid; p_tid[slot] = tid;
        end
        gjerp_pkg::OP_SCHED: p_sch[slot] = ts;
        default: p_sig[slot] = ts;
      endcase
      if (have[slot] != gjerp_pkg::KIND_ALL) return;
      hw = (p_sch[slot] < latest[tl]) ? latest[tl] : p_sch[slot];
      r = -1;
      sat = 0;
      for (int d = 0; d < rows[tl]; d++)
        if (r < 0 && p_sub[slot] >= row_end[tl][d] + {32'b0, slack}) r = d;
      if (r < 0) begin
        if (rows[tl] < DEPTH) begin
          r = rows[tl];
          rows[tl]++;
        end else begin
          r = DEPTH - 1;
          sat = 1;
        end
      end
      row_end[tl][r] = p_sig[slot];
      j.status = sat ? gjerp_pkg::ST_SAT : gjerp_pkg::ST_DONE;
      j.pid = p_pid[slot]; j.tid = p_tid[slot];
      j.ctx = ctx; j.seq = seq; j.tl = tl; j.row = r[3:0];
      j.t_sub = p_sub[slot]; j.t_sch = p_sch[slot]; j.t_hw = hw; j.t_sig = p_sig[slot];
      pending_jobs = {pending_jobs, j};
      if (p_sig[slot] > latest[tl]) latest[tl] = p_sig[slot];
      have[slot] = '0;
    endfunction

    function void check_job(job_t got);
      job_t exp_j;
      if (pending_jobs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_j = pending_jobs.pop_front();
      if (got.status != exp_j.status) report("status", exp_j.status, got.status);
      if (got.pid != exp_j.pid) report("pid", exp_j.pid, got.pid);
      if (got.tid != exp_j.tid) report("tid", exp_j.tid, got.tid);
      if (got.ctx != exp_j.ctx) report("context", exp_j.ctx, got.ctx);
      if (got.seq != exp_j.seq) report("seqno", exp_j.seq, got.seq);
      if (got.tl != exp_j.tl) report("timeline", exp_j.tl, got.tl);
      if (got.row != exp_j.row) report("row", exp_j.row, got.row);
      if (got.t_sub != exp_j.t_sub) report("submit", exp_j.t_sub, got.t_sub);
      if (got.t_sch != exp_j.t_sch) report("schedule", exp_j.t_sch, got.t_sch);
      if (got.t_hw != exp_j.t_hw) report("hw start", exp_j.t_hw, got.t_hw);
      if (got.t_sig != exp_j.t_sig) report("signal", exp_j.t_sig, got.t_sig);
    endfunction

    function void report(string what, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, what, e, a);
      errors++;
    endfunction
  endclass

  logic         clk, rst;
  logic         cfg_valid, cfg_ready;
  logic [31:0]  cfg_data;
  logic         s_tvalid, s_tready;
  logic [183:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [375:0] m_tdata;
  logic [1:0]   m_tuser;

  gpu_job_event_join_and_row_packer u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  job_scoreboard sb;
  longint cycle = 0;
  bit     idle_gaps;      // random idling on both sides
  bit     hold_req;       // receiver hold-off request
  bit     hold_done;
  int     hold_cycles;    // counted down by the receiver
  int     sent;
  int     seq_base;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      hold_cycles <= 0;
      hold_done <= 0;
    end else begin
      if (m_tvalid && m_tready)
        sb.check_job({m_tuser, m_tdata[22:0], m_tdata[45:23], m_tdata[77:46],
                      m_tdata[109:78], m_tdata[112:110], m_tdata[116:113],
                      m_tdata[180:117], m_tdata[244:181], m_tdata[308:245],
                      m_tdata[372:309]});
      if (hold_req && !hold_done) begin
        hold_done <= 1;
        hold_cycles <= 400;
        m_tready <= 0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 0;
      end else begin
        m_tready <= idle_gaps ? ($urandom_range(99) >= 27) : 1'b1;
      end
    end
  end

  // One event transfer; a random idle gap precedes it. Valid stays up for
  // a following event and is dropped by drain().
  task automatic send_event(logic [1:0] op, logic [63:0] ts, logic [31:0] ctx,
                            logic [31:0] seq, logic [2:0] tl, logic [22:0] pid,
                            logic [22:0] tid);
    while (idle_gaps && $urandom_range(99) < 27) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {9'b0, tid, pid, tl, seq, ctx, ts};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(op, ts, ctx, seq, tl, pid, tid);
    sent++;
  endtask

  task automatic write_slack(logic [31:0] v);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.slack = v;
  endtask

  // wait out all results, then the longest scan latency
  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_jobs.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A complete job: three kinds in random order with random content, optionally repeating the first kind.
  task automatic send_job(logic [31:0] ctx, logic [31:0] seq, logic [2:0] tl,
                          logic [63:0] t0, bit dup);
    int order [3];
    logic [63:0] ts [3];
    int k;
    order = '{0, 1, 2};
    order.shuffle();
    ts[0] = t0;
    ts[1] = t0 + $urandom_range(5000);
    ts[2] = ts[1] + $urandom_range(3000000);
    foreach (order[i]) begin
      k = order[i];
      send_event(k[1:0], ts[k], ctx, seq, tl, 23'($urandom), 23'($urandom));
      if (dup && i == 0)
        send_event(k[1:0], rand64(), ctx, seq, tl, 23'($urandom), 23'($urandom));
    end
  endtask

  logic [63:0] now_ns [NTL];

  initial begin
    sb = new();
    sb.clear();
    idle_gaps = 0; hold_req = 0; sent = 0;
    rst = 1; cfg_valid = 0; cfg_data = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every opcode, repeated kind, bad opcode.
    send_event(gjerp_pkg::OP_SUBMIT, '1, '1, '1, 3'd7, '1, '1);
    send_event(gjerp_pkg::OP_SUBMIT, '0, '1, '1, 3'd7, '0, '0);   // repeated kind
    send_event(gjerp_pkg::OP_SCHED, '1, '1, '1, 3'd7, '0, '0);
    send_event(gjerp_pkg::OP_RSVD, rand64(), '1, '1, 3'd7, '1, '1);  // unknown opcode
    send_event(gjerp_pkg::OP_SIGNAL, '1, '1, '1, 3'd7, '0, '0);
    send_event(gjerp_pkg::OP_SIGNAL, '0, '0, '0, 3'd0, '0, '0);
    send_event(gjerp_pkg::OP_SCHED, '0, '0, '0, 3'd0, '1, '1);
    send_event(gjerp_pkg::OP_SUBMIT, '0, '0, '0, 3'd0, 23'h400000, 23'h2AAAAA);
    // slack wrap: row end near 2^64 plus slack wraps below the submit time
    send_job(32'h5, 32'h5, 3'd7, 64'd2000000, 0);
    // table full: fill sixteen entries with lone submits, then two new keys drop
    for (int i = 0; i < NPEND + 2; i++)
      send_event(gjerp_pkg::OP_SUBMIT, rand64(), 32'hF000 + i, i, 3'd1,
                 23'($urandom), 23'($urandom));
    for (int i = 0; i < NPEND; i++) begin
      send_event(gjerp_pkg::OP_SCHED, 64'd100, 32'hF000 + i, i, 3'd1, '0, '0);
      send_event(gjerp_pkg::OP_SIGNAL, 64'd200, 32'hF000 + i, i, 3'd1, '0, '0);
    end
    drain();

    // Configuration phases, extremes included, then random traffic.
    foreach (now_ns[i]) now_ns[i] = $urandom_range(1000);
    seq_base = 0;
    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: write_slack(32'd0);
        1: write_slack(32'hFFFF_FFFF);
        2: write_slack(gjerp_pkg::SLACK_RESET);
        3: write_slack($urandom);
        default: write_slack($urandom_range(2000000));
      endcase
      idle_gaps = (ph != 2);
      if (ph == 3) hold_req = 1;   // receiver holds off, input backs up
      for (int n = 0; n < 100; n++) begin
        int tl;
        tl = $urandom_range(NTL - 1);
        if ($urandom_range(99) < 85) begin
          // deep stacks: overlapping jobs reach saturation on busy timelines
          now_ns[tl] += $urandom_range(tl < 2 ? 100 : 1500000);
          send_job($urandom_range(3), seq_base++, tl[2:0], now_ns[tl],
                   $urandom_range(9) == 0);
        end else begin
          send_event(2'($urandom_range(3)), rand64(), $urandom, $urandom,
                     3'($urandom), 23'($urandom), 23'($urandom));
        end
      end
      drain();
      // complete stray lone entries so the next phase starts with an empty table
      for (int e = 0; e < NPEND; e++) begin
        logic [2:0] hk;
        hk = sb.have[e];
        if (hk != 0)
          for (int k = 0; k < 3; k++)
            if (!hk[k])
              send_event(k[1:0], rand64(), sb.p_ctx[e], sb.p_seq[e], sb.p_tl[e],
                         23'($urandom), 23'($urandom));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_jobs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
